FILE: rtl/core/cid_pkg.sv
// Package for the CPU16 instruction decoder: variant codes, opcode and
// mnemonic codes, operand format codes and the decoded result word.
// No dependencies.
package cid_pkg;

  typedef logic [1:0] variant_t;
  localparam variant_t VAR_ORIG  = 2'd0;
  localparam variant_t VAR_EXT   = 2'd1;
  localparam variant_t VAR_UCODE = 2'd2;

  // Register addresses (word index in the configuration space)
  localparam logic REG_CPU_VARIANT = 1'b0;

  typedef logic [4:0] opcode_t;
  localparam opcode_t OP_LDRL = 5'h00;
  localparam opcode_t OP_COND = 5'h01;
  localparam opcode_t OP_STRL = 5'h02;
  localparam opcode_t OP_BIT  = 5'h03;
  localparam opcode_t OP_LDR  = 5'h04;
  localparam opcode_t OP_XOR  = 5'h05;
  localparam opcode_t OP_STR  = 5'h06;
  localparam opcode_t OP_ADC  = 5'h07;
  localparam opcode_t OP_SETL = 5'h08;
  localparam opcode_t OP_SXT  = 5'h09;
  localparam opcode_t OP_SETH = 5'h0a;
  localparam opcode_t OP_SUBB = 5'h0b;
  localparam opcode_t OP_MOVL = 5'h0c;
  localparam opcode_t OP_SBC  = 5'h0d;
  localparam opcode_t OP_MOVH = 5'h0e;
  localparam opcode_t OP_MOV  = 5'h10;
  localparam opcode_t OP_ADD  = 5'h11;
  localparam opcode_t OP_GGET = 5'h12;
  localparam opcode_t OP_SUB  = 5'h13;
  localparam opcode_t OP_GSET = 5'h14;
  localparam opcode_t OP_SHL  = 5'h15;
  localparam opcode_t OP_B    = 5'h16;
  localparam opcode_t OP_SHR  = 5'h17;
  localparam opcode_t OP_SETP = 5'h18;
  localparam opcode_t OP_AND  = 5'h19;
  localparam opcode_t OP_GETP = 5'h1a;
  localparam opcode_t OP_OR   = 5'h1b;
  localparam opcode_t OP_GETF = 5'h1c;
  localparam opcode_t OP_INV  = 5'h1d;
  localparam opcode_t OP_XOR3 = 5'h1f;

  // Microcode core long call / jump: upper nibble of the low byte
  localparam logic [3:0] UC_CALL_NIB = 4'h7;
  localparam logic [3:0] UC_JMP_NIB  = 4'hf;
  // Microcode core return encoding
  localparam logic [7:0] RET_LO = 8'h80;
  localparam logic [7:0] RET_HI = 8'h40;
  // Global index masks
  localparam logic [7:0] GMASK_UCODE = 8'h3f;
  localparam logic [7:0] GMASK_EXT   = 8'h1f;

  typedef logic [5:0] mnem_t;
  localparam mnem_t MN_DW    = 6'd0;
  localparam mnem_t MN_CALL  = 6'd1;
  localparam mnem_t MN_JMP   = 6'd2;
  localparam mnem_t MN_CBZ   = 6'd3;
  localparam mnem_t MN_CBNZ  = 6'd4;
  localparam mnem_t MN_ADC   = 6'd5;
  localparam mnem_t MN_SBC   = 6'd6;
  localparam mnem_t MN_XOR   = 6'd7;
  localparam mnem_t MN_LDRL  = 6'd8;
  localparam mnem_t MN_STRL  = 6'd9;
  localparam mnem_t MN_LDR   = 6'd10;
  localparam mnem_t MN_STR   = 6'd11;
  localparam mnem_t MN_SETL  = 6'd12;
  localparam mnem_t MN_SETH  = 6'd13;
  localparam mnem_t MN_LDI8  = 6'd14;
  localparam mnem_t MN_MOVL  = 6'd15;
  localparam mnem_t MN_MOVH  = 6'd16;
  localparam mnem_t MN_RET   = 6'd17;
  localparam mnem_t MN_MOV   = 6'd18;
  localparam mnem_t MN_SWS   = 6'd19;
  localparam mnem_t MN_GGET  = 6'd20;
  localparam mnem_t MN_SWU   = 6'd21;
  localparam mnem_t MN_GSET  = 6'd22;
  localparam mnem_t MN_B     = 6'd23;
  localparam mnem_t MN_SETP  = 6'd24;
  localparam mnem_t MN_GGETR = 6'd25;
  localparam mnem_t MN_GETP  = 6'd26;
  localparam mnem_t MN_GSETR = 6'd27;
  localparam mnem_t MN_GETF  = 6'd28;
  localparam mnem_t MN_EQ    = 6'd29;
  localparam mnem_t MN_BTC   = 6'd37;
  localparam mnem_t MN_SXT   = 6'd39;
  localparam mnem_t MN_SUBB  = 6'd40;
  localparam mnem_t MN_ADD   = 6'd41;
  localparam mnem_t MN_SUB   = 6'd42;
  localparam mnem_t MN_SHL   = 6'd43;
  localparam mnem_t MN_SHR   = 6'd44;
  localparam mnem_t MN_AND   = 6'd45;
  localparam mnem_t MN_OR    = 6'd46;
  localparam mnem_t MN_INV   = 6'd47;
  localparam mnem_t MN_LAST  = 6'd47;

  // Operand layout of a decoded instruction
  typedef enum logic [3:0] {
    FMT_NONE,
    FMT_TGT,
    FMT_CB,
    FMT_ABT,
    FMT_BT,
    FMT_IMM8,
    FMT_GLOB,
    FMT_AB,
    FMT_A
  } fmt_t;

  typedef struct packed {
    logic [15:0] raw_word;
    logic [15:0] target;
    logic [7:0]  immediate;
    logic [2:0]  third_reg;
    logic        third_is_imm;
    logic [2:0]  reg_b;
    logic [2:0]  reg_a;
    mnem_t       mnemonic;
  } dec_out_t;

endpackage

FILE: rtl/core/cid_cfg_regs.sv
// APB-style configuration register for the CPU16 instruction decoder.
// Holds the CPU variant. Depends on cid_pkg.
module cid_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cid_pkg::variant_t  variant
);

  cid_pkg::variant_t variant_r;
  cid_pkg::variant_t variant_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    variant_nxt = variant_r;
    if (wr_en && paddr[2] == cid_pkg::REG_CPU_VARIANT) begin
      variant_nxt = pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= cid_pkg::VAR_ORIG;
    end else begin
      variant_r <= variant_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == cid_pkg::REG_CPU_VARIANT) begin
      prdata = {30'd0, variant_r};
    end
  end

  assign variant = variant_r;

endmodule

FILE: rtl/core/cid_decode.sv
// Combinational decode of one 16-bit instruction word into mnemonic,
// operand fields and branch target. Depends on cid_pkg.
module cid_decode (
  input  cid_pkg::variant_t  variant,
  input  logic [15:0]        word_address,
  input  logic [7:0]         low_byte,
  input  logic [7:0]         high_byte,
  output cid_pkg::dec_out_t  dec
);

  cid_pkg::opcode_t op;
  logic [2:0]       ra;
  logic [2:0]       rb;
  logic [4:0]       opnd;
  logic             uc;
  logic             orig;
  logic             uc_long;
  logic             uc_reject;
  cid_pkg::mnem_t   mn;
  cid_pkg::fmt_t    fmt;
  logic [15:0]      tgt;
  logic [12:0]      cb_tgt;
  logic [15:0]      b_tgt;
  logic [15:0]      long_tgt;
  logic [7:0]       gmask;

  assign op   = low_byte[7:3];
  assign ra   = low_byte[2:0];
  assign rb   = high_byte[7:5];
  assign opnd = high_byte[4:0];
  assign uc   = (variant == cid_pkg::VAR_UCODE);
  assign orig = (variant == cid_pkg::VAR_ORIG);

  assign uc_long = uc && (low_byte[7:4] == cid_pkg::UC_CALL_NIB ||
                          low_byte[7:4] == cid_pkg::UC_JMP_NIB);

  // Microcode core forbids pc as destination of these encodings
  assign uc_reject = uc && ra == 3'd0 &&
                     (op == cid_pkg::OP_LDRL || op == cid_pkg::OP_LDR ||
                      op == cid_pkg::OP_SETL || op == cid_pkg::OP_SETH ||
                      op == cid_pkg::OP_MOVL || op == cid_pkg::OP_GETF ||
                      (op[0] && op != cid_pkg::OP_COND && op != cid_pkg::OP_BIT));

  assign long_tgt = {3'd0, low_byte[3:0], high_byte, 1'b0};
  assign cb_tgt   = word_address[12:0] + {{6{high_byte[5]}}, high_byte[5:0], 1'b0};
  assign b_tgt    = word_address + {{4{ra[2]}}, ra, high_byte, 1'b0};
  assign gmask    = uc ? cid_pkg::GMASK_UCODE : cid_pkg::GMASK_EXT;

  always_comb begin
    mn  = cid_pkg::MN_DW;
    fmt = cid_pkg::FMT_NONE;
    tgt = 16'd0;
    if (uc_long) begin
      mn  = (low_byte[7:4] == cid_pkg::UC_CALL_NIB) ? cid_pkg::MN_CALL : cid_pkg::MN_JMP;
      fmt = cid_pkg::FMT_TGT;
      tgt = long_tgt;
    end else if (orig && (op == cid_pkg::OP_SUBB || op == cid_pkg::OP_GETF)) begin
      mn = cid_pkg::MN_DW;
    end else if (op == cid_pkg::OP_GETF && high_byte != 8'd0) begin
      // compare-and-branch lives in the getf slot with a nonzero high byte
      if (uc && high_byte[7:6] != 2'b00 && high_byte[7:6] != 2'b11) begin
        mn  = high_byte[7] ? cid_pkg::MN_CBNZ : cid_pkg::MN_CBZ;
        fmt = cid_pkg::FMT_CB;
        tgt = {3'd0, cb_tgt};
      end
    end else if (uc_reject) begin
      mn = cid_pkg::MN_DW;
    end else begin
      unique case (op)
        cid_pkg::OP_ADC: begin
          if (uc) begin
            mn  = cid_pkg::MN_ADC;
            fmt = cid_pkg::FMT_ABT;
          end
        end
        cid_pkg::OP_SBC: begin
          if (uc) begin
            mn  = cid_pkg::MN_SBC;
            fmt = cid_pkg::FMT_ABT;
          end
        end
        cid_pkg::OP_XOR: begin
          if (uc) begin
            mn  = cid_pkg::MN_XOR;
            fmt = cid_pkg::FMT_ABT;
          end
        end
        cid_pkg::OP_LDRL: begin mn = cid_pkg::MN_LDRL; fmt = cid_pkg::FMT_ABT;  end
        cid_pkg::OP_STRL: begin mn = cid_pkg::MN_STRL; fmt = cid_pkg::FMT_ABT;  end
        cid_pkg::OP_LDR:  begin mn = cid_pkg::MN_LDR;  fmt = cid_pkg::FMT_ABT;  end
        cid_pkg::OP_STR:  begin mn = cid_pkg::MN_STR;  fmt = cid_pkg::FMT_ABT;  end
        cid_pkg::OP_SETL: begin mn = cid_pkg::MN_SETL; fmt = cid_pkg::FMT_IMM8; end
        cid_pkg::OP_SETH: begin mn = cid_pkg::MN_SETH; fmt = cid_pkg::FMT_IMM8; end
        cid_pkg::OP_MOVL: begin
          if (uc) begin
            mn  = cid_pkg::MN_LDI8;
            fmt = cid_pkg::FMT_IMM8;
          end else begin
            mn  = cid_pkg::MN_MOVL;
            fmt = cid_pkg::FMT_AB;
          end
        end
        cid_pkg::OP_MOVH: begin mn = cid_pkg::MN_MOVH; fmt = cid_pkg::FMT_AB; end
        cid_pkg::OP_MOV: begin
          if (uc && low_byte == cid_pkg::RET_LO && high_byte == cid_pkg::RET_HI) begin
            mn = cid_pkg::MN_RET;
          end else begin
            mn  = cid_pkg::MN_MOV;
            fmt = cid_pkg::FMT_AB;
          end
        end
        cid_pkg::OP_GGET: begin
          if (orig) begin
            mn = cid_pkg::MN_SWS;
          end else begin
            mn  = cid_pkg::MN_GGET;
            fmt = cid_pkg::FMT_GLOB;
          end
        end
        cid_pkg::OP_GSET: begin
          if (orig) begin
            mn = cid_pkg::MN_SWU;
          end else begin
            mn  = cid_pkg::MN_GSET;
            fmt = cid_pkg::FMT_GLOB;
          end
        end
        cid_pkg::OP_B: begin
          mn  = cid_pkg::MN_B;
          fmt = cid_pkg::FMT_TGT;
          tgt = b_tgt;
        end
        cid_pkg::OP_SETP: begin
          if (orig) begin
            mn  = cid_pkg::MN_SETP;
            fmt = cid_pkg::FMT_A;
          end else begin
            mn  = cid_pkg::MN_GGETR;
            fmt = cid_pkg::FMT_AB;
          end
        end
        cid_pkg::OP_GETP: begin
          if (orig) begin
            mn  = cid_pkg::MN_GETP;
            fmt = cid_pkg::FMT_A;
          end else begin
            mn  = cid_pkg::MN_GSETR;
            fmt = cid_pkg::FMT_AB;
          end
        end
        cid_pkg::OP_GETF: begin mn = cid_pkg::MN_GETF; fmt = cid_pkg::FMT_A; end
        cid_pkg::OP_COND: begin
          // register A field selects the condition
          mn  = cid_pkg::MN_EQ + {3'd0, ra};
          fmt = cid_pkg::FMT_BT;
        end
        cid_pkg::OP_BIT: begin
          if (ra[2:1] == 2'b00) begin
            mn  = cid_pkg::MN_BTC + {5'd0, ra[0]};
            fmt = cid_pkg::FMT_BT;
          end
        end
        cid_pkg::OP_SXT:  begin mn = cid_pkg::MN_SXT;  fmt = cid_pkg::FMT_AB;  end
        cid_pkg::OP_SUBB: begin mn = cid_pkg::MN_SUBB; fmt = cid_pkg::FMT_ABT; end
        cid_pkg::OP_ADD:  begin mn = cid_pkg::MN_ADD;  fmt = cid_pkg::FMT_ABT; end
        cid_pkg::OP_SUB:  begin mn = cid_pkg::MN_SUB;  fmt = cid_pkg::FMT_ABT; end
        cid_pkg::OP_SHL:  begin mn = cid_pkg::MN_SHL;  fmt = cid_pkg::FMT_ABT; end
        cid_pkg::OP_SHR:  begin mn = cid_pkg::MN_SHR;  fmt = cid_pkg::FMT_ABT; end
        cid_pkg::OP_AND:  begin mn = cid_pkg::MN_AND;  fmt = cid_pkg::FMT_ABT; end
        cid_pkg::OP_OR:   begin mn = cid_pkg::MN_OR;   fmt = cid_pkg::FMT_ABT; end
        cid_pkg::OP_INV:  begin mn = cid_pkg::MN_INV;  fmt = cid_pkg::FMT_AB;  end
        cid_pkg::OP_XOR3: begin mn = cid_pkg::MN_XOR;  fmt = cid_pkg::FMT_ABT; end
        default: begin
          mn  = cid_pkg::MN_DW;
          fmt = cid_pkg::FMT_NONE;
        end
      endcase
    end
  end

  // Assemble the operand fields from the layout
  always_comb begin
    dec              = '0;
    dec.mnemonic     = mn;
    dec.raw_word     = {high_byte, low_byte};
    dec.target       = tgt;
    if (fmt == cid_pkg::FMT_CB || fmt == cid_pkg::FMT_ABT || fmt == cid_pkg::FMT_IMM8 ||
        fmt == cid_pkg::FMT_GLOB || fmt == cid_pkg::FMT_AB || fmt == cid_pkg::FMT_A) begin
      dec.reg_a = ra;
    end
    if (fmt == cid_pkg::FMT_ABT || fmt == cid_pkg::FMT_BT || fmt == cid_pkg::FMT_AB) begin
      dec.reg_b = rb;
    end
    if (fmt == cid_pkg::FMT_ABT || fmt == cid_pkg::FMT_BT) begin
      if (opnd[0]) begin
        dec.third_is_imm = 1'b1;
        dec.immediate    = {4'd0, opnd[4:1]};
      end else begin
        dec.third_reg = opnd[4:2];
      end
    end
    if (fmt == cid_pkg::FMT_IMM8) begin
      dec.immediate = high_byte;
    end
    if (fmt == cid_pkg::FMT_GLOB) begin
      dec.immediate = high_byte & gmask;
    end
  end

endmodule

FILE: rtl/core/cpu16_instruction_decoder_unit.sv
// Top level of the CPU16 instruction decoder: input register, decode logic
// and result register. Depends on cid_pkg, cid_cfg_regs and cid_decode.
// The input word is registered in the input stage, decoded combinationally, and then
// registered in the result register before it is on out_. Throughput: one word per
// cycle; both stages advance together when the result register is empty or being taken.
// Reset (synchronous, rst_n low): both stages empty, cpu_variant = 0.
module cpu16_instruction_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] word_address, [23:16] low_byte, [31:24] high_byte
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] mnemonic, [8:6] reg_a, [11:9] reg_b, [12] third_is_imm,
  // [15:13] third_reg, [23:16] immediate, [39:24] target, [55:40] raw_word
  output logic [55:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cid_pkg::variant_t variant;
  cid_pkg::dec_out_t dec;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [31:0] s1_data_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  cid_pkg::dec_out_t out_data_r;
  logic        out_load;
  logic        s1_load;

  cid_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .variant (variant)
  );

  cid_decode u_dec (
    .variant      (variant),
    .word_address (s1_data_r[15:0]),
    .low_byte     (s1_data_r[23:16]),
    .high_byte    (s1_data_r[31:24]),
    .dec          (dec)
  );

  // Result register takes a new word when empty or when drained this cycle
  assign out_load  = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | out_load;
  assign s1_load   = in_tvalid & in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_tdata;
    end
    if (out_load) begin
      out_data_r <= dec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_raw_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_data_r.raw_word == $past({s1_data_r[31:24], s1_data_r[23:16]}))
    else $error("raw word does not follow the decoded input");

  a_dw_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.mnemonic == cid_pkg::MN_DW |->
      out_data_r.target == 16'd0 && out_data_r.reg_a == 3'd0 &&
      out_data_r.immediate == 8'd0)
    else $error("data word carries operand fields");

  a_third_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.third_is_imm |-> out_data_r.third_reg == 3'd0)
    else $error("third operand both immediate and register");

  a_mn_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.mnemonic <= cid_pkg::MN_LAST)
    else $error("mnemonic out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking bench for cpu16_instruction_decoder_unit: directed table (some rows with hand-written
// expected results), then random words under each CPU variant checked against a local decode predictor.
// Depends on cid_pkg and the decoder RTL.
module testbench;
  import cid_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int WORDS_PER_PHASE = 95;
  localparam int HOLD_AT_WORD = 150;
  localparam int HOLD_CYCLES = 60;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cpu16_instruction_decoder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  typedef struct {
    variant_t    cpu;
    logic [15:0] addr;
    logic [7:0]  lo;
    logic [7:0]  hi;
    bit          typed;
    dec_out_t    want;
  } dir_row_t;

  localparam int NDIR = 27;
  dir_row_t dir_tab [0:NDIR-1] = '{
    '{VAR_ORIG,  16'h0000, 8'h00, 8'h00, 1'b1, '{mnemonic: MN_LDRL, default: 0}},
    '{VAR_ORIG,  16'hffff, 8'hff, 8'hff, 1'b0, '0},
    '{VAR_ORIG,  16'h1234, 8'h58, 8'h77, 1'b1, '{raw_word: 16'h7758, default: 0}},
    '{VAR_ORIG,  16'h0000, 8'he0, 8'h41, 1'b1, '{raw_word: 16'h41e0, default: 0}},
    '{VAR_ORIG,  16'hfffe, 8'h90, 8'hff, 1'b1,
      '{mnemonic: MN_SWS, raw_word: 16'hff90, default: 0}},
    '{VAR_ORIG,  16'h0101, 8'ha3, 8'h3c, 1'b1,
      '{mnemonic: MN_SWU, raw_word: 16'h3ca3, default: 0}},
    '{VAR_ORIG,  16'h0200, 8'hc5, 8'he7, 1'b0, '0},
    '{VAR_ORIG,  16'h0300, 8'hd2, 8'h18, 1'b0, '0},
    '{VAR_ORIG,  16'h0400, 8'h0f, 8'ha6, 1'b0, '0},
    '{VAR_ORIG,  16'h0500, 8'h19, 8'h35, 1'b0, '0},
    '{VAR_ORIG,  16'h0000, 8'h1a, 8'h55, 1'b1, '{raw_word: 16'h551a, default: 0}},
    '{VAR_ORIG,  16'h0010, 8'hb4, 8'h00, 1'b0, '0},
    '{VAR_ORIG,  16'hfff0, 8'hb3, 8'hff, 1'b0, '0},
    '{VAR_EXT,   16'h0000, 8'h90, 8'hff, 1'b0, '0},
    '{VAR_EXT,   16'h0000, 8'he3, 8'h00, 1'b0, '0},
    '{VAR_EXT,   16'h0000, 8'he0, 8'h41, 1'b1, '{raw_word: 16'h41e0, default: 0}},
    '{VAR_EXT,   16'h0000, 8'h60, 8'h5a, 1'b0, '0},
    '{VAR_EXT,   16'h8000, 8'h5d, 8'h2c, 1'b0, '0},
    '{VAR_UCODE, 16'h0000, 8'h80, 8'h40, 1'b1,
      '{mnemonic: MN_RET, raw_word: 16'h4080, default: 0}},
    '{VAR_UCODE, 16'h0000, 8'h7a, 8'h34, 1'b1,
      '{mnemonic: MN_CALL, target: 16'h1468, raw_word: 16'h347a, default: 0}},
    '{VAR_UCODE, 16'h0000, 8'hff, 8'hff, 1'b1,
      '{mnemonic: MN_JMP, target: 16'h1ffe, raw_word: 16'hffff, default: 0}},
    '{VAR_UCODE, 16'hffff, 8'he1, 8'h60, 1'b0, '0},
    '{VAR_UCODE, 16'h0000, 8'he2, 8'h9f, 1'b0, '0},
    '{VAR_UCODE, 16'h0000, 8'he2, 8'hc0, 1'b1, '{raw_word: 16'hc0e2, default: 0}},
    '{VAR_UCODE, 16'h0000, 8'h38, 8'h5b, 1'b1, '{raw_word: 16'h5b38, default: 0}},
    '{VAR_UCODE, 16'h0000, 8'h61, 8'hab, 1'b0, '0},
    '{2'd3,      16'h0000, 8'h90, 8'hff, 1'b0, '0}
  };

  variant_t cpu_sel;
  dec_out_t word_exp;
  dec_out_t pending_decodes[$];
  int       n_bad;
  int       n_checked;
  int       n_sent;
  int       cycles;
  bit       quiet;
  bit       mn_seen [0:63];

  function automatic dec_out_t decode_word(variant_t v, logic [15:0] addr,
                                           logic [7:0] lo, logic [7:0] hi);
    opcode_t     op;
    logic [2:0]  ra;
    logic [4:0]  opnd;
    logic        uc;
    logic        orig;
    fmt_t        fmt;
    logic [15:0] off;
    dec_out_t    d;
    op   = lo[7:3];
    ra   = lo[2:0];
    opnd = hi[4:0];
    uc   = (v == VAR_UCODE);
    orig = (v == VAR_ORIG);
    fmt  = FMT_NONE;
    d    = '0;
    d.raw_word = {hi, lo};
    if (uc && (lo[7:4] == UC_CALL_NIB || lo[7:4] == UC_JMP_NIB)) begin
      d.mnemonic = (lo[7:4] == UC_CALL_NIB) ? MN_CALL : MN_JMP;
      fmt = FMT_TGT;
      d.target = {3'b000, lo[3:0], hi, 1'b0};
    end else if (orig && (op == OP_SUBB || op == OP_GETF)) begin
      d.mnemonic = MN_DW;
    end else if (op == OP_GETF && hi != 8'h00) begin
      // compare-and-branch lives in getf space with a nonzero high byte
      if (uc && (hi[7:6] == 2'b01 || hi[7:6] == 2'b10)) begin
        d.mnemonic = hi[7] ? MN_CBNZ : MN_CBZ;
        fmt = FMT_CB;
        off = {{9{hi[5]}}, hi[5:0], 1'b0};
        d.target = (addr + off) & 16'h1fff;
      end
    end else if (uc && ra == 3'd0 &&
                 (op == OP_LDRL || op == OP_LDR || op == OP_SETL || op == OP_SETH ||
                  op == OP_MOVL || op == OP_GETF ||
                  (op[0] && op != OP_COND && op != OP_BIT))) begin
      d.mnemonic = MN_DW;
    end else begin
      case (op)
        OP_ADC: if (uc) begin d.mnemonic = MN_ADC; fmt = FMT_ABT; end
        OP_SBC: if (uc) begin d.mnemonic = MN_SBC; fmt = FMT_ABT; end
        OP_XOR: if (uc) begin d.mnemonic = MN_XOR; fmt = FMT_ABT; end
        OP_LDRL: begin d.mnemonic = MN_LDRL; fmt = FMT_ABT; end
        OP_STRL: begin d.mnemonic = MN_STRL; fmt = FMT_ABT; end
        OP_LDR:  begin d.mnemonic = MN_LDR;  fmt = FMT_ABT; end
        OP_STR:  begin d.mnemonic = MN_STR;  fmt = FMT_ABT; end
        OP_SETL: begin d.mnemonic = MN_SETL; fmt = FMT_IMM8; end
        OP_SETH: begin d.mnemonic = MN_SETH; fmt = FMT_IMM8; end
        OP_MOVL: begin
          if (uc) begin d.mnemonic = MN_LDI8; fmt = FMT_IMM8; end
          else begin d.mnemonic = MN_MOVL; fmt = FMT_AB; end
        end
        OP_MOVH: begin d.mnemonic = MN_MOVH; fmt = FMT_AB; end
        OP_MOV: begin
          if (uc && lo == RET_LO && hi == RET_HI) d.mnemonic = MN_RET;
          else begin d.mnemonic = MN_MOV; fmt = FMT_AB; end
        end
        OP_GGET: begin
          if (orig) d.mnemonic = MN_SWS;
          else begin d.mnemonic = MN_GGET; fmt = FMT_GLOB; end
        end
        OP_GSET: begin
          if (orig) d.mnemonic = MN_SWU;
          else begin d.mnemonic = MN_GSET; fmt = FMT_GLOB; end
        end
        OP_B: begin
          off = {{4{ra[2]}}, ra, hi, 1'b0};
          d.mnemonic = MN_B;
          fmt = FMT_TGT;
          d.target = addr + off;
        end
        OP_SETP: begin
          if (orig) begin d.mnemonic = MN_SETP; fmt = FMT_A; end
          else begin d.mnemonic = MN_GGETR; fmt = FMT_AB; end
        end
        OP_GETP: begin
          if (orig) begin d.mnemonic = MN_GETP; fmt = FMT_A; end
          else begin d.mnemonic = MN_GSETR; fmt = FMT_AB; end
        end
        OP_GETF: begin d.mnemonic = MN_GETF; fmt = FMT_A; end
        // register A picks the condition or bit test
        OP_COND: begin d.mnemonic = MN_EQ + mnem_t'(ra); fmt = FMT_BT; end
        OP_BIT: if (ra <= 3'd1) begin d.mnemonic = MN_BTC + mnem_t'(ra); fmt = FMT_BT; end
        OP_SXT:  begin d.mnemonic = MN_SXT;  fmt = FMT_AB; end
        OP_SUBB: begin d.mnemonic = MN_SUBB; fmt = FMT_ABT; end
        OP_ADD:  begin d.mnemonic = MN_ADD;  fmt = FMT_ABT; end
        OP_SUB:  begin d.mnemonic = MN_SUB;  fmt = FMT_ABT; end
        OP_SHL:  begin d.mnemonic = MN_SHL;  fmt = FMT_ABT; end
        OP_SHR:  begin d.mnemonic = MN_SHR;  fmt = FMT_ABT; end
        OP_AND:  begin d.mnemonic = MN_AND;  fmt = FMT_ABT; end
        OP_OR:   begin d.mnemonic = MN_OR;   fmt = FMT_ABT; end
        OP_INV:  begin d.mnemonic = MN_INV;  fmt = FMT_AB; end
        OP_XOR3: begin d.mnemonic = MN_XOR;  fmt = FMT_ABT; end
        default: ;
      endcase
    end
    if (fmt inside {FMT_CB, FMT_ABT, FMT_IMM8, FMT_GLOB, FMT_AB, FMT_A}) d.reg_a = ra;
    if (fmt inside {FMT_ABT, FMT_BT, FMT_AB}) d.reg_b = hi[7:5];
    if (fmt inside {FMT_ABT, FMT_BT}) begin
      if (opnd[0]) begin
        d.third_is_imm = 1'b1;
        d.immediate = {4'h0, opnd[4:1]};
      end else begin
        d.third_reg = opnd[4:2];
      end
    end
    if (fmt == FMT_IMM8) d.immediate = hi;
    if (fmt == FMT_GLOB) d.immediate = hi & (uc ? GMASK_UCODE : GMASK_EXT);
    return d;
  endfunction

  task automatic check_decode(dec_out_t got, dec_out_t want);
    string diff;
    diff = "";
    if (got.mnemonic !== want.mnemonic) diff = {diff, " mnemonic"};
    if (got.reg_a !== want.reg_a) diff = {diff, " reg_a"};
    if (got.reg_b !== want.reg_b) diff = {diff, " reg_b"};
    if (got.third_is_imm !== want.third_is_imm) diff = {diff, " third_is_imm"};
    if (got.third_reg !== want.third_reg) diff = {diff, " third_reg"};
    if (got.immediate !== want.immediate) diff = {diff, " immediate"};
    if (got.target !== want.target) diff = {diff, " target"};
    if (got.raw_word !== want.raw_word) diff = {diff, " raw_word"};
    n_checked++;
    mn_seen[want.mnemonic] = 1'b1;
    if (diff != "") begin
      n_bad++;
      if (n_bad <= 10)
        $display("mismatch [%s ] word %h: got mn=%0d a=%0d b=%0d ti=%0d tr=%0d imm=%h tgt=%h,",
                 diff, want.raw_word, got.mnemonic, got.reg_a, got.reg_b,
                 got.third_is_imm, got.third_reg, got.immediate, got.target,
                 " want mn=%0d a=%0d b=%0d ti=%0d tr=%0d imm=%h tgt=%h",
                 want.mnemonic, want.reg_a, want.reg_b, want.third_is_imm,
                 want.third_reg, want.immediate, want.target);
    end
  endtask

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycles,
               pending_decodes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // scoreboard: queue on input acceptance, retire on output acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) pending_decodes.push_back(word_exp);
      if (out_tvalid && out_tready) begin
        if (pending_decodes.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result word %h", out_tdata);
        end else begin
          check_decode(dec_out_t'(out_tdata), pending_decodes.pop_front());
        end
      end
    end
  end

  // result side: short random stalls, one long hold-off, none at the end
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && !held && n_sent >= HOLD_AT_WORD) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic [15:0] addr, logic [7:0] lo, logic [7:0] hi,
                           dec_out_t want);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo, addr};
    word_exp  <= want;
    n_sent++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic pause_in();
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat ($urandom_range(0, 3)) @(negedge clk);
  endtask

  // drain, then write the variant and read it back over the config port
  task automatic set_variant(variant_t v);
    logic [31:0] rd;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= {REG_CPU_VARIANT, 2'b00};
    cfg_pwdata <= {30'd0, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cpu_sel = v;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== {30'd0, v}) begin
      n_bad++;
      if (n_bad <= 10) $display("cpu_variant read back %h, want %h", rd, v);
    end
  endtask

  // mostly legal opcodes with random operands, some raw noise and edge words
  task automatic pick_word(output logic [15:0] addr, output logic [7:0] lo,
                           output logic [7:0] hi);
    case ($urandom_range(0, 7))
      0: addr = 16'h0000;
      1: addr = 16'hffff;
      default: addr = 16'($urandom);
    endcase
    hi = 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1: lo = 8'($urandom);
      2: begin
        lo = RET_LO;
        hi = RET_HI;
      end
      3: begin
        lo = {OP_GETF, 3'($urandom)};
        if ($urandom_range(0, 2) == 0) hi = 8'h00;
      end
      default: lo = {5'($urandom), 3'($urandom_range(0, 7))};
    endcase
  endtask

  initial begin
    logic [15:0] a;
    logic [7:0]  l;
    logic [7:0]  h;
    variant_t    phase_cpu [0:3];
    int          n_mn;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cpu_sel = VAR_ORIG;
    word_exp = '0;
    n_bad = 0;
    n_checked = 0;
    n_sent = 0;
    cycles = 0;
    quiet = 1'b0;
    foreach (mn_seen[i]) mn_seen[i] = 1'b0;
    phase_cpu = '{VAR_UCODE, VAR_ORIG, VAR_EXT, VAR_UCODE};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NDIR; i++) begin
      if (dir_tab[i].cpu != cpu_sel) set_variant(dir_tab[i].cpu);
      if ($urandom_range(0, 3) == 0) pause_in();
      send_word(dir_tab[i].addr, dir_tab[i].lo, dir_tab[i].hi,
                dir_tab[i].typed ? dir_tab[i].want :
                decode_word(cpu_sel, dir_tab[i].addr, dir_tab[i].lo, dir_tab[i].hi));
    end

    for (int p = 0; p < 4; p++) begin
      set_variant(phase_cpu[p]);
      if (p == 3) quiet = 1'b1;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (!quiet && $urandom_range(0, 3) == 0) pause_in();
        pick_word(a, l, h);
        send_word(a, l, h, decode_word(cpu_sel, a, l, h));
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    n_mn = 0;
    foreach (mn_seen[i]) if (mn_seen[i]) n_mn++;
    $display("Decoded %0d words over all four variant settings, with stalls and a long",
             n_checked);
    $display("output hold-off; %0d distinct mnemonics (data word included) came out.", n_mn);
    if (n_bad == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cid_pkg.sv
rtl/core/cid_cfg_regs.sv
rtl/core/cid_decode.sv
rtl/core/cpu16_instruction_decoder_unit.sv
test/testbench.sv
